/* hw/rtl/hcg_pkg.sv */
package hcg_pkg;

  localparam int MAX_STOPS   = 16;
  localparam int CH_W        = 8;
  localparam int POS_W       = 16;
  localparam int IDX_W       = $clog2(MAX_STOPS);
  localparam int CNT_W       = $clog2(MAX_STOPS + 1);
  localparam int COUNT_OUT_W = 5;
  localparam int F_W         = POS_W + 1;
  localparam int DIV_STEPS   = F_W;
  localparam int DEF_STOPS   = 5;
  localparam int DEF_COUNT   = (MAX_STOPS < DEF_STOPS) ? MAX_STOPS : DEF_STOPS;
  localparam int POS_ONE     = 1 << (POS_W - 1);
  localparam int POS_QUARTER = POS_ONE / 4;

  localparam int S_TDATA_W = 2 * POS_W + 3 * CH_W;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = ((3 * CH_W + COUNT_OUT_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } stop_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] at;
    stop_t            stop;
  } ins_req_t;

  // five-stop heatmap: blue, cyan, green, yellow, red at even spacing
  function automatic stop_t default_stop(int unsigned i);
    stop_t s;
    s = '0;
    case (i)
      0: begin
        s.blue = '1;
      end
      1: begin
        s.green = '1;
        s.blue  = '1;
      end
      2: begin
        s.green = '1;
      end
      3: begin
        s.red   = '1;
        s.green = '1;
      end
      4: begin
        s.red = '1;
      end
      default: begin
        s = '0;
      end
    endcase
    if (i < DEF_STOPS) begin
      s.pos = POS_W'(i * POS_QUARTER);
    end
    return s;
  endfunction

endpackage

/* hw/rtl/heatmap_color_gradient.sv */
// Piecewise linear color gradient over a sorted table of color stops.
// Input stream s_*: s_tuser carries the operation (lookup, insert, clear),
// s_tdata the lookup value, the stop position and the stop color.
// Output stream m_*: exactly one transaction per input transaction, with
// m_tuser holding the status and m_tdata the color and the stop count.
// The block works on one item at a time: s_tready is high only while idle.
// Lookup: a scan over the stops (up to the stop count), a fetch of the lower
// stop, the 17-step restoring divider, the shared blend multiplier and the
// hand-off of the result; a lookup below the first stop or at or above the
// last stop skips the divider. Insert: a scan over the stops, up to one past
// the last stop, then a write and the hand-off. Clear, unknown operations,
// lookups on an empty table and inserts into a full table go straight to the
// hand-off. s_tready rises in the cycle after the hand-off.
// The result sits in an output register; a stalled receiver holds the block
// in its hand-off state until the register frees up.
// Reset loads the five-stop heatmap (blue, cyan, green, yellow, red at
// 0, 0.25, 0.5, 0.75, 1.0) and empties the output register.
module heatmap_color_gradient (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // lookup_value, stop_position, stop_red, stop_green, stop_blue
  input  logic [hcg_pkg::S_TDATA_W-1:0]     s_tdata,
  // operation
  input  logic [hcg_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // red_out, green_out, blue_out, stop_count_out, zero fill
  output logic [hcg_pkg::M_TDATA_W-1:0]     m_tdata,
  // status
  output logic [hcg_pkg::M_TUSER_W-1:0]     m_tuser
);
  import hcg_pkg::*;

  localparam int PW = CH_W + F_W + 2;
  localparam logic signed [PW-1:0] ROUND_C = PW'(1 << (POS_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PREV,
    S_DIV,
    S_BLEND,
    S_ISEARCH,
    S_IWRITE,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             found;
  logic [POS_W-1:0] val;
  stop_t            new_stop;
  stop_t            cur;
  stop_t            prv;
  logic [F_W-1:0]   f;
  logic [1:0]       bcnt;
  logic signed [PW-1:0] prod;
  logic [CH_W-1:0]  qd;
  logic [CH_W-1:0]  res_r;
  logic [CH_W-1:0]  res_g;
  logic [CH_W-1:0]  res_b;
  status_t          res_status;

  op_t              in_op;
  logic [IDX_W-1:0] rd_addr;
  stop_t            rd;
  ins_req_t         ins;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [F_W-1:0]   div_quot;
  logic [POS_W-1:0] div_num;
  logic [POS_W-1:0] div_den;

  logic [CH_W-1:0]      p_ch;
  logic [CH_W-1:0]      q_ch;
  logic signed [CH_W:0] dif_s;
  logic signed [F_W:0]  f_s;
  logic signed [PW-1:0] mul;
  logic signed [PW-1:0] rnd;
  logic [CH_W-1:0]      blend;

  assign in_op    = op_t'(s_tuser);
  assign s_tready = (state == S_IDLE);

  // the lower neighbor is read in the cycle after the upper stop is found
  always_comb begin
    if (state == S_PREV && found && idx != '0) begin
      rd_addr = idx[IDX_W-1:0] - IDX_W'(1);
    end else begin
      rd_addr = idx[IDX_W-1:0];
    end
  end

  assign ins.en   = (state == S_IWRITE);
  assign ins.at   = idx[IDX_W-1:0];
  assign ins.stop = new_stop;

  hcg_stop_table u_table (
    .clk     (clk),
    .rst     (rst),
    .ins     (ins),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  assign div_start = (state == S_PREV) && (rd.pos != cur.pos);
  assign div_num   = cur.pos - val;
  assign div_den   = cur.pos - rd.pos;

  hcg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // channel = cur + round((prev - cur) * f / 2^16), one channel per cycle
  always_comb begin
    unique case (bcnt)
      2'd0: begin
        p_ch = prv.red;
        q_ch = cur.red;
      end
      2'd1: begin
        p_ch = prv.green;
        q_ch = cur.green;
      end
      default: begin
        p_ch = prv.blue;
        q_ch = cur.blue;
      end
    endcase
  end

  assign dif_s = $signed({1'b0, p_ch}) - $signed({1'b0, q_ch});
  assign f_s   = $signed({1'b0, f});
  assign mul   = PW'(dif_s) * PW'(f_s);
  assign rnd   = prod + ROUND_C;
  assign blend = qd + rnd[POS_W+CH_W-1:POS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= CNT_W'(DEF_COUNT);
      m_tvalid <= 1'b0;
      idx      <= '0;
      found    <= 1'b0;
      bcnt     <= '0;
    end else begin
      // the hand-off state refills the register itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            val      <= s_tdata[POS_W-1:0];
            new_stop <= {s_tdata[2*POS_W-1:POS_W],
                         s_tdata[2*POS_W+CH_W-1:2*POS_W],
                         s_tdata[2*POS_W+2*CH_W-1:2*POS_W+CH_W],
                         s_tdata[2*POS_W+3*CH_W-1:2*POS_W+2*CH_W]};
            idx      <= '0;
            found    <= 1'b0;
            res_r    <= '0;
            res_g    <= '0;
            res_b    <= '0;
            unique case (in_op)
              OP_LOOKUP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SEARCH;
                end
              end
              OP_INSERT: begin
                if (count >= CNT_W'(MAX_STOPS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_ISEARCH;
                end
              end
              OP_CLEAR: begin
                count      <= '0;
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (val < rd.pos) begin
            found <= 1'b1;
            cur   <= rd;
            state <= S_PREV;
          end else if (idx == count - CNT_W'(1)) begin
            cur   <= rd;
            state <= S_PREV;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_PREV: begin
          prv <= rd;
          if (rd.pos == cur.pos) begin
            f     <= '0;
            bcnt  <= '0;
            state <= S_BLEND;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            f     <= div_quot;
            bcnt  <= '0;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          prod <= mul;
          qd   <= q_ch;
          bcnt <= bcnt + 2'd1;
          unique case (bcnt)
            2'd1: begin
              res_r <= blend;
            end
            2'd2: begin
              res_g <= blend;
            end
            2'd3: begin
              res_b      <= blend;
              res_status <= ST_OK;
              state      <= S_DONE;
            end
            default: begin
            end
          endcase
        end
        S_ISEARCH: begin
          if (idx == count || new_stop.pos < rd.pos) begin
            state <= S_IWRITE;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_IWRITE: begin
          count      <= count + CNT_W'(1);
          res_status <= ST_DONE;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'({COUNT_OUT_W'(count), res_b, res_g, res_r});
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_STOPS))
    else $error("stop count beyond table size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    state == S_IWRITE |-> count < CNT_W'(MAX_STOPS))
    else $error("insert into a full table");

  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[3*CH_W-1:0] == '0)
    else $error("color nonzero on a result without a valid color");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    state != S_DIV |-> !div_busy)
    else $error("divider busy outside the divide state");

endmodule

/* hw/rtl/hcg_stop_table.sv */
module hcg_stop_table (
  input  logic                          clk,
  input  logic                          rst,
  input  hcg_pkg::ins_req_t             ins,
  input  logic [hcg_pkg::IDX_W-1:0]     rd_addr,
  output hcg_pkg::stop_t                rd_data
);
  import hcg_pkg::*;

  stop_t entry [MAX_STOPS];

  // insert: entries above the slot all move up by one in the same cycle
  for (genvar g = 0; g < MAX_STOPS; g++) begin : g_entry
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          entry[g] <= default_stop(g);
        end else if (ins.en && ins.at == IDX_W'(g)) begin
          entry[g] <= ins.stop;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          entry[g] <= default_stop(g);
        end else if (ins.en) begin
          if (ins.at == IDX_W'(g)) begin
            entry[g] <= ins.stop;
          end else if (ins.at < IDX_W'(g)) begin
            entry[g] <= entry[g-1];
          end
        end
      end
    end
  end

  assign rd_data = entry[rd_addr];

endmodule

/* hw/rtl/hcg_divider.sv */
module hcg_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hcg_pkg::POS_W-1:0]   num,
  input  logic [hcg_pkg::POS_W-1:0]   den,
  output logic                        busy,
  output logic                        done,
  output logic [hcg_pkg::F_W-1:0]     quot
);
  import hcg_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [POS_W:0]   rem;
  logic [POS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             first;
  logic [POS_W:0]   trial;
  logic [POS_W:0]   diff;
  logic             ge;

  // first step tests the integer bit, so (num << 16) / den needs only 17 steps
  assign trial = first ? rem : {rem[POS_W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(DIV_STEPS);
        rem   <= {1'b0, num};
        dvs   <= den;
        first <= 1'b1;
        quot  <= '0;
      end else if (busy) begin
        rem   <= ge ? diff : trial;
        quot  <= {quot[F_W-2:0], ge};
        first <= 1'b0;
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_steps: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(DIV_STEPS + 1) done)
    else $error("divider done not after fixed step count");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done longer than one cycle");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule
